// ===== hw/rtl/hsd_pkg.sv =====
`default_nettype none

package hsd_pkg;

  typedef enum logic [1:0] {
    DIR_ERR  = 2'd0,
    DIR_NONE = 2'd1,
    DIR_FWD  = 2'd2,
    DIR_REV  = 2'd3
  } dir_e;

  localparam int unsigned CODE_BITS   = 3;
  localparam int unsigned PERIOD_BITS = 32;
  localparam int unsigned OVF_BITS    = 32;
  localparam int unsigned SECTORS     = 6;
  localparam int unsigned SECTOR_BITS = $clog2(SECTORS);

  localparam logic [CODE_BITS-1:0] CODE_INV_MASK = 3'h7;
  localparam logic [CODE_BITS-1:0] CODE_PERIOD   = 3'd1;
  localparam logic [CODE_BITS-1:0] CODE_MIN      = 3'd1;
  localparam logic [CODE_BITS-1:0] CODE_MAX      = 3'd6;
  localparam logic [CODE_BITS-1:0] SECTOR_FIRST  = 3'd1;
  localparam logic [CODE_BITS-1:0] SECTOR_LAST   = 3'd6;

  // indexed by {previous, new}
  localparam dir_e STEP_TABLE [64] = '{
    DIR_ERR, DIR_ERR,  DIR_ERR,  DIR_ERR,  DIR_ERR,  DIR_ERR,  DIR_ERR,  DIR_ERR,
    DIR_ERR, DIR_NONE, DIR_ERR,  DIR_FWD,  DIR_ERR,  DIR_REV,  DIR_ERR,  DIR_ERR,
    DIR_ERR, DIR_ERR,  DIR_NONE, DIR_REV,  DIR_ERR,  DIR_ERR,  DIR_FWD,  DIR_ERR,
    DIR_ERR, DIR_REV,  DIR_FWD,  DIR_NONE, DIR_ERR,  DIR_ERR,  DIR_ERR,  DIR_ERR,
    DIR_ERR, DIR_ERR,  DIR_ERR,  DIR_ERR,  DIR_NONE, DIR_FWD,  DIR_REV,  DIR_ERR,
    DIR_ERR, DIR_FWD,  DIR_ERR,  DIR_ERR,  DIR_REV,  DIR_NONE, DIR_ERR,  DIR_ERR,
    DIR_ERR, DIR_ERR,  DIR_REV,  DIR_ERR,  DIR_FWD,  DIR_ERR,  DIR_NONE, DIR_ERR,
    DIR_ERR, DIR_ERR,  DIR_ERR,  DIR_ERR,  DIR_ERR,  DIR_ERR,  DIR_ERR,  DIR_ERR
  };

endpackage

`default_nettype wire

// ===== hw/rtl/hall_sensor_decoder.sv =====
// an accepted input beat is registered as its result beat
// throughput: one beat per cycle while no result beat waits under out_stall_i; table lookup
// and period subtract sit between the input handshake and the result register
// in_stall_o rises only while a result beat waits under out_stall_i
// reset (async, active low): previous code 0, sign positive, captures 0,
// learned codes 0, run mode
`default_nettype none

module hall_sensor_decoder
  import hsd_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,

  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic                   cfg_data_i,

  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [CODE_BITS-1:0]   hall_code_i,
  input  wire logic [TIMER_BITS-1:0]  timer_count_i,
  input  wire logic [OVF_BITS-1:0]    overflow_count_i,
  input  wire logic                   duty_negative_i,
  input  wire logic                   motor_fault_i,
  input  wire logic [CODE_BITS-1:0]   study_sector_i,

  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [1:0]                  direction_o,
  output logic [PERIOD_BITS-1:0]      period_o,
  output logic                        period_valid_o,
  output logic                        commutate_valid_o,
  output logic [CODE_BITS-1:0]        commutate_code_o,
  output logic                        hall_fault_o
);

  logic                   study_mode_q;
  logic [CODE_BITS-1:0]   prev_code_q;
  logic                   sign_q, sign_d;
  logic [TIMER_BITS-1:0]  last_cap_q;
  logic [OVF_BITS-1:0]    last_ovf_q;
  logic [CODE_BITS-1:0]   learned_q [SECTORS];

  logic                   out_valid_q;
  dir_e                   dir_q;
  logic [PERIOD_BITS-1:0] period_q;
  logic                   period_valid_q;
  logic                   comm_valid_q;
  logic [CODE_BITS-1:0]   comm_code_q;
  logic                   hall_fault_q;

  logic                   accept;
  dir_e                   raw_dir, dir_d;
  logic                   is_step;
  logic                   capture;
  logic [OVF_BITS-1:0]    ovf_diff;
  logic [PERIOD_BITS-1:0] ovf_wide;
  logic [PERIOD_BITS-1:0] timer_diff;
  logic [PERIOD_BITS-1:0] period_d;
  logic                   comm_valid_d;
  logic [CODE_BITS-1:0]   comm_code_d;
  logic                   hall_fault_d;
  logic                   learn_wr;
  logic [SECTOR_BITS-1:0] learn_idx;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;

  always_comb begin
    raw_dir = STEP_TABLE[{prev_code_q, hall_code_i}];
    dir_d   = raw_dir;
    if (sign_q) begin
      case (raw_dir)
        DIR_FWD: dir_d = DIR_REV;
        DIR_REV: dir_d = DIR_FWD;
        default: dir_d = raw_dir;
      endcase
    end
  end

  assign is_step = (dir_d == DIR_FWD) || (dir_d == DIR_REV);

  // period over timer ticks, overflows weighted by the timer span
  assign ovf_diff   = overflow_count_i - last_ovf_q;
  assign ovf_wide   = ovf_diff << TIMER_BITS;
  assign timer_diff = PERIOD_BITS'(timer_count_i) - PERIOD_BITS'(last_cap_q);

  always_comb begin
    capture      = 1'b0;
    period_d     = '0;
    comm_valid_d = 1'b0;
    comm_code_d  = '0;
    hall_fault_d = 1'b0;
    sign_d       = sign_q;
    if (study_mode_q) begin
      hall_fault_d = (hall_code_i < CODE_MIN) || (hall_code_i > CODE_MAX);
      if (dir_d == DIR_REV) begin
        sign_d = ~sign_q;
      end
    end else if (is_step) begin
      if (hall_code_i == CODE_PERIOD) begin
        capture  = 1'b1;
        period_d = timer_diff + ovf_wide;
      end
      if (!motor_fault_i) begin
        comm_valid_d = 1'b1;
        comm_code_d  = duty_negative_i ? (hall_code_i ^ CODE_INV_MASK) : hall_code_i;
      end
    end
  end

  // learned table takes valid codes at sectors one to six
  assign learn_wr  = study_mode_q && !hall_fault_d && (study_sector_i >= SECTOR_FIRST)
                     && (study_sector_i <= SECTOR_LAST);
  assign learn_idx = SECTOR_BITS'(study_sector_i - SECTOR_FIRST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      study_mode_q <= 1'b0;
      prev_code_q  <= '0;
      sign_q       <= 1'b0;
      last_cap_q   <= '0;
      last_ovf_q   <= '0;
      learned_q    <= '{default: '0};
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        study_mode_q <= cfg_data_i;
      end
      if (accept) begin
        prev_code_q <= hall_code_i;
        sign_q      <= sign_d;
        if (capture) begin
          last_cap_q <= timer_count_i;
          last_ovf_q <= overflow_count_i;
        end
        if (learn_wr) begin
          learned_q[learn_idx] <= hall_code_i;
        end
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result beat payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dir_q          <= dir_d;
      period_q       <= period_d;
      period_valid_q <= capture;
      comm_valid_q   <= comm_valid_d;
      comm_code_q    <= comm_code_d;
      hall_fault_q   <= hall_fault_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign direction_o       = dir_q;
  assign period_o          = period_q;
  assign period_valid_o    = period_valid_q;
  assign commutate_valid_o = comm_valid_q;
  assign commutate_code_o  = comm_code_q;
  assign hall_fault_o      = hall_fault_q;

endmodule

`default_nettype wire

// ===== hw/rtl/hsd_checker.sv =====
`default_nettype none

module hsd_checker
  import hsd_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   out_valid_o,
  input wire logic                   out_stall_i,
  input wire logic [1:0]             direction_o,
  input wire logic [PERIOD_BITS-1:0] period_o,
  input wire logic                   period_valid_o,
  input wire logic                   commutate_valid_o,
  input wire logic [CODE_BITS-1:0]   commutate_code_o,
  input wire logic                   hall_fault_o
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(direction_o) && $stable(period_o)
      && $stable(commutate_code_o))
    else $error("stalled result beat changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !period_valid_o |-> period_o == '0)
    else $error("period without capture");

  // captures and commutation only follow a real step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (period_valid_o || commutate_valid_o) |->
      (direction_o == DIR_FWD || direction_o == DIR_REV))
    else $error("capture or commutation without a step");

  // a hall fault only comes from study mode, where nothing is issued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (hall_fault_o || !commutate_valid_o) |->
      !(hall_fault_o && (period_valid_o || commutate_valid_o)) && commutate_code_o == '0)
    else $error("hall fault or idle commutation with output");

endmodule

bind hall_sensor_decoder hsd_checker u_hsd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .direction_o       (direction_o),
  .period_o          (period_o),
  .period_valid_o    (period_valid_o),
  .commutate_valid_o (commutate_valid_o),
  .commutate_code_o  (commutate_code_o),
  .hall_fault_o      (hall_fault_o)
);

`default_nettype wire
